// ----- rtl/core/tad_pkg.sv -----
// ----------------------------------------------------------------------------
// tad_pkg
// Types and constants shared by the teletext attribute decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tad_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_CHAR  = 2'd0;
    localparam logic [1:0] OP_ROW   = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FLASH_FIRST  = 2'd0;
    localparam logic [1:0] CFG_FLASH_PERIOD = 2'd1;

    localparam logic [7:0] FLASH_FIRST_RESET  = 8'd35;
    localparam logic [7:0] FLASH_PERIOD_RESET = 8'd50;

    // character codes
    localparam logic [7:0] GLYPH_SPACE      = 8'd32;
    localparam logic [7:0] CODE_DEL         = 8'd127;
    localparam logic [7:0] CODE_ALPHA_BLACK = 8'd128;
    localparam logic [7:0] CODE_ALPHA_RED   = 8'd129;
    localparam logic [7:0] CODE_ALPHA_WHITE = 8'd135;
    localparam logic [7:0] CODE_STEADY      = 8'd136;
    localparam logic [7:0] CODE_FLASH       = 8'd137;
    localparam logic [7:0] CODE_END_BOX     = 8'd138;
    localparam logic [7:0] CODE_START_BOX   = 8'd139;
    localparam logic [7:0] CODE_NORMAL_HT   = 8'd140;
    localparam logic [7:0] CODE_DOUBLE_HT   = 8'd141;
    localparam logic [7:0] CODE_RSVD_LO     = 8'd142;
    localparam logic [7:0] CODE_RSVD_HI     = 8'd144;
    localparam logic [7:0] CODE_MOS_RED     = 8'd145;
    localparam logic [7:0] CODE_MOS_WHITE   = 8'd151;
    localparam logic [7:0] CODE_CONCEAL     = 8'd152;
    localparam logic [7:0] CODE_CONTIGUOUS  = 8'd153;
    localparam logic [7:0] CODE_SEPARATED   = 8'd154;
    localparam logic [7:0] CODE_RSVD_ESC    = 8'd155;
    localparam logic [7:0] CODE_BLACK_BG    = 8'd156;
    localparam logic [7:0] CODE_NEW_BG      = 8'd157;
    localparam logic [7:0] CODE_HOLD        = 8'd158;
    localparam logic [7:0] CODE_RELEASE     = 8'd159;

    // height modes and double-height row phases
    localparam logic [1:0] HT_NORMAL = 2'd0;
    localparam logic [1:0] HT_UPPER  = 2'd1;
    localparam logic [1:0] HT_LOWER  = 2'd2;

    localparam logic [2:0] COLOUR_BLACK = 3'd0;
    localparam logic [2:0] COLOUR_WHITE = 3'd7;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
    } t_in;

    typedef struct packed {
        logic [7:0] glyph;
        logic       mosaic;
        logic       separated;
        logic [2:0] fg_colour;
        logic [2:0] bg_colour;
        logic [1:0] height_mode;
    } t_out;

    // class of a beat as sorted by the front end
    typedef enum logic [4:0] {
        K_NONE,
        K_ROW,
        K_FRAME,
        K_BLANK,
        K_PRINT,
        K_TEXT_COL,
        K_STEADY,
        K_FLASH,
        K_NORMAL,
        K_DOUBLE,
        K_GFX_COL,
        K_CONCEAL,
        K_CONTIG,
        K_SEP,
        K_BLACK_BG,
        K_NEW_BG,
        K_HOLD,
        K_RELEASE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_wr;

endpackage

`default_nettype wire

// ----- rtl/core/tad_front.sv -----
// ----------------------------------------------------------------------------
// tad_front
// Input stage: takes beats, sorts each byte into its attribute class and
// holds the result in a register until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tad_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tad_pkg::t_in  i_in_data,
    output logic               o_item_valid,
    input  wire logic          i_item_ready,
    output tad_pkg::t_item     o_item
);
    import tad_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;

    function automatic t_kind classify(input logic [1:0] op, input logic [7:0] c);
        t_kind k;
        k = K_NONE;
        if (op == OP_ROW) begin
            k = K_ROW;
        end else if (op == OP_FRAME) begin
            k = K_FRAME;
        end else if (op == OP_CHAR) begin
            unique case (c) inside
                [8'd0:GLYPH_SPACE - 8'd1]:            k = K_BLANK;
                [GLYPH_SPACE:CODE_DEL]:               k = K_PRINT;
                CODE_ALPHA_BLACK:                     k = K_BLANK;
                [CODE_ALPHA_RED:CODE_ALPHA_WHITE]:    k = K_TEXT_COL;
                CODE_STEADY:                          k = K_STEADY;
                CODE_FLASH:                           k = K_FLASH;
                CODE_END_BOX, CODE_START_BOX:         k = K_BLANK;
                CODE_NORMAL_HT:                       k = K_NORMAL;
                CODE_DOUBLE_HT:                       k = K_DOUBLE;
                [CODE_RSVD_LO:CODE_RSVD_HI]:          k = K_BLANK;
                [CODE_MOS_RED:CODE_MOS_WHITE]:        k = K_GFX_COL;
                CODE_CONCEAL:                         k = K_CONCEAL;
                CODE_CONTIGUOUS:                      k = K_CONTIG;
                CODE_SEPARATED:                       k = K_SEP;
                CODE_RSVD_ESC:                        k = K_BLANK;
                CODE_BLACK_BG:                        k = K_BLACK_BG;
                CODE_NEW_BG:                          k = K_NEW_BG;
                CODE_HOLD:                            k = K_HOLD;
                CODE_RELEASE:                         k = K_RELEASE;
                default:                              k = K_PRINT;
            endcase
        end
        return k;
    endfunction

    assign o_in_ready   = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_in_ready) begin
            n_valid     = i_in_valid;
            n_item.kind = classify(i_in_data.op, i_in_data.char_code);
            n_item.code = i_in_data.char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

`default_nettype wire

// ----- rtl/core/tad_queue.sv -----
// ----------------------------------------------------------------------------
// tad_queue
// Small first-in first-out queue of classified beats between the front and
// back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tad_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire tad_pkg::t_item i_push_item,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output tad_pkg::t_item      o_pop_item
);
    import tad_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL  = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tad_back.sv -----
// ----------------------------------------------------------------------------
// tad_back
// Execution stage: applies each classified beat to the serial attribute
// state, runs the flash timer and drives the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module tad_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tad_pkg::t_cfg_wr i_cfg,
    input  wire logic             i_item_valid,
    output logic                  o_item_ready,
    input  wire tad_pkg::t_item   i_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tad_pkg::t_out         o_out_data
);
    import tad_pkg::*;

    logic [7:0] r_flash_first, n_flash_first;
    logic [7:0] r_flash_period, n_flash_period;
    logic [2:0] r_fg, n_fg;
    logic [2:0] r_bg, n_bg;
    logic       r_gfx, n_gfx;
    logic       r_sep, n_sep;
    logic       r_conceal, n_conceal;
    logic       r_flash_hidden, n_flash_hidden;
    logic       r_hold, n_hold;
    logic [7:0] r_held, n_held;
    logic [7:0] r_prev, n_prev;
    logic [1:0] r_height, n_height;
    logic [1:0] r_row_phase, n_row_phase;
    logic [7:0] r_flash_count, n_flash_count;
    logic       r_flash_phase, n_flash_phase;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;

    logic       pop;
    logic       is_char;
    logic [7:0] hold_show;
    logic [7:0] hold_pick;
    logic [7:0] frame_count;
    logic [2:0] colour;

    assign o_item_ready = !r_out_valid || i_out_ready;
    assign pop          = i_item_valid && o_item_ready;
    assign is_char      = (i_item.kind != K_NONE) && (i_item.kind != K_ROW)
                          && (i_item.kind != K_FRAME);
    assign hold_show    = r_hold ? r_held : GLYPH_SPACE;
    assign hold_pick    = r_gfx ? r_prev : GLYPH_SPACE;
    assign frame_count  = r_flash_count + 8'd1;
    assign colour       = i_item.code[2:0];
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    always_comb begin
        n_flash_first  = r_flash_first;
        n_flash_period = r_flash_period;
        n_fg           = r_fg;
        n_bg           = r_bg;
        n_gfx          = r_gfx;
        n_sep          = r_sep;
        n_conceal      = r_conceal;
        n_flash_hidden = r_flash_hidden;
        n_hold         = r_hold;
        n_held         = r_held;
        n_prev         = r_prev;
        n_height       = r_height;
        n_row_phase    = r_row_phase;
        n_flash_count  = r_flash_count;
        n_flash_phase  = r_flash_phase;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out          = r_out;

        if (i_cfg.valid) begin
            if (i_cfg.index == CFG_FLASH_FIRST) begin
                n_flash_first = i_cfg.data;
            end else if (i_cfg.index == CFG_FLASH_PERIOD) begin
                n_flash_period = i_cfg.data;
            end
        end

        if (pop) begin
            // background changes land on this cell, the rest after it (a hold code also shows its glyph here)
            if (i_item.kind == K_BLACK_BG) begin
                n_bg = COLOUR_BLACK;
            end else if (i_item.kind == K_NEW_BG) begin
                n_bg = r_fg;
            end

            n_out.glyph       = GLYPH_SPACE;
            n_out.mosaic      = r_gfx;
            n_out.separated   = r_gfx && r_sep;
            n_out.fg_colour   = r_fg;
            n_out.bg_colour   = n_bg;
            n_out.height_mode = r_height;

            if (is_char) begin
                n_out_valid = 1'b1;
                n_prev      = i_item.code;
            end

            unique case (i_item.kind)
                K_ROW: begin
                    n_fg           = COLOUR_WHITE;
                    n_bg           = COLOUR_BLACK;
                    n_gfx          = 1'b0;
                    n_sep          = 1'b0;
                    n_conceal      = 1'b0;
                    n_flash_hidden = 1'b0;
                    n_hold         = 1'b0;
                    n_held         = GLYPH_SPACE;
                    n_prev         = GLYPH_SPACE;
                    n_height       = HT_NORMAL;
                    // upper goes to lower, lower goes to none
                    if (r_row_phase == HT_UPPER) begin
                        n_row_phase = HT_LOWER;
                    end else begin
                        n_row_phase = HT_NORMAL;
                    end
                end
                K_FRAME: begin
                    n_row_phase = HT_NORMAL;
                    if (frame_count == r_flash_first) begin
                        n_flash_phase = !r_flash_phase;
                        n_flash_count = frame_count;
                    end else if (frame_count == r_flash_period) begin
                        n_flash_phase = !r_flash_phase;
                        n_flash_count = 8'd0;
                    end else begin
                        n_flash_count = frame_count;
                    end
                end
                K_BLANK: begin
                    n_held = GLYPH_SPACE;
                end
                K_PRINT: begin
                    n_out.glyph = (r_flash_hidden || r_conceal) ? GLYPH_SPACE
                                                                : i_item.code;
                    n_held      = GLYPH_SPACE;
                end
                K_TEXT_COL: begin
                    n_gfx     = 1'b0;
                    n_fg      = colour;
                    n_conceal = 1'b0;
                    n_held    = GLYPH_SPACE;
                end
                K_STEADY: begin
                    n_out.glyph    = hold_show;
                    n_flash_hidden = 1'b0;
                    n_conceal      = 1'b0;
                end
                K_FLASH: begin
                    n_out.glyph    = hold_show;
                    n_flash_hidden = r_flash_phase;
                    n_conceal      = 1'b0;
                end
                K_NORMAL: begin
                    n_out.glyph = hold_show;
                    n_height    = HT_NORMAL;
                end
                K_DOUBLE: begin
                    n_held = GLYPH_SPACE;
                    if (r_row_phase == HT_LOWER) begin
                        n_height = HT_LOWER;
                    end else begin
                        n_row_phase = HT_UPPER;
                        n_height    = HT_UPPER;
                    end
                end
                K_GFX_COL: begin
                    n_out.glyph = r_conceal ? GLYPH_SPACE : r_held;
                    n_conceal   = 1'b0;
                    n_gfx       = 1'b1;
                    n_fg        = colour;
                end
                K_CONCEAL: begin
                    n_conceal = 1'b1;
                    n_held    = GLYPH_SPACE;
                end
                K_CONTIG: begin
                    n_out.glyph = hold_show;
                    n_sep       = 1'b0;
                end
                K_SEP: begin
                    n_out.glyph = hold_show;
                    n_sep       = 1'b1;
                end
                K_HOLD: begin
                    n_hold      = 1'b1;
                    n_held      = hold_pick;
                    n_out.glyph = hold_pick;
                end
                K_RELEASE: begin
                    n_held = GLYPH_SPACE;
                    n_hold = 1'b0;
                end
                default: begin
                    // background codes and unused ops change nothing more
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_first  <= FLASH_FIRST_RESET;
            r_flash_period <= FLASH_PERIOD_RESET;
            r_fg           <= COLOUR_WHITE;
            r_bg           <= COLOUR_BLACK;
            r_gfx          <= 1'b0;
            r_sep          <= 1'b0;
            r_conceal      <= 1'b0;
            r_flash_hidden <= 1'b0;
            r_hold         <= 1'b0;
            r_held         <= GLYPH_SPACE;
            r_prev         <= GLYPH_SPACE;
            r_height       <= HT_NORMAL;
            r_row_phase    <= HT_NORMAL;
            r_flash_count  <= 8'd0;
            r_flash_phase  <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_flash_first  <= n_flash_first;
            r_flash_period <= n_flash_period;
            r_fg           <= n_fg;
            r_bg           <= n_bg;
            r_gfx          <= n_gfx;
            r_sep          <= n_sep;
            r_conceal      <= n_conceal;
            r_flash_hidden <= n_flash_hidden;
            r_hold         <= n_hold;
            r_held         <= n_held;
            r_prev         <= n_prev;
            r_height       <= n_height;
            r_row_phase    <= n_row_phase;
            r_flash_count  <= n_flash_count;
            r_flash_phase  <= n_flash_phase;
            r_out_valid    <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// ----- rtl/core/teletext_attribute_decoder.sv -----
// ----------------------------------------------------------------------------
// teletext_attribute_decoder
// Serial attribute decoder for teletext character rows.
// ----------------------------------------------------------------------------
// Takes one beat per clock while nothing stalls: a character byte, a start
// of row or a frame tick, and returns one result per character byte carrying
// the glyph and its drawing attributes. Sustained rate is one beat per cycle
// when nothing stalls, set by the attribute state update in the back end.
// A beat is registered and classified in the front end, passes a
// QUEUE_DEPTH-entry queue and is executed into an output register, where its
// result is offered. Row starts and frame ticks give no result. The flash
// timer registers are written through the config port, which is always
// ready; write them only while the decoder is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module teletext_attribute_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tad_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output tad_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [7:0]    i_cfg_data
);
    import tad_pkg::*;

    logic    front_valid;
    logic    front_ready;
    t_item   front_item;
    logic    queue_valid;
    logic    queue_ready;
    t_item   queue_item;
    t_cfg_wr cfg;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    tad_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready),
        .o_item       (front_item)
    );

    tad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_item   (queue_item)
    );

    tad_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (queue_valid),
        .o_item_ready (queue_ready),
        .i_item       (queue_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

// ----- dv/tb_teletext_attribute_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_teletext_attribute_decoder
// Self-checking testbench for the teletext serial attribute decoder.
// ----------------------------------------------------------------------------
// Streams character, row start and frame tick beats into the decoder and
// predicts every decoded cell with an attribute model kept alongside it.
// Covers a directed sweep of the control codes, the flash timer at several
// register settings, and long runs of random rows. Both sides stall in
// random bursts, except in the final stretch.
// ----------------------------------------------------------------------------
module tb_teletext_attribute_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import tad_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic       i_clk     = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in        in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = CFG_FLASH_FIRST;
    logic [7:0] cfg_data  = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out       o_out_data;
    logic       o_cfg_ready;

    bit         idle_en = 1'b0;
    int         stall_left = 0;
    int         quiet_cycles = 0;
    int         mismatch_count = 0;
    t_out       pending_cells[$];

    // attribute model state
    logic [2:0] fg_now, bg_now;
    logic       mosaic_now, sep_now, conceal_now, flash_off, hold_now;
    logic [7:0] held_code, last_code;
    logic [1:0] ht_now, dh_phase;
    logic [7:0] frame_cnt;
    logic       flash_state;
    logic [7:0] toggle_at, period_at;

    teletext_attribute_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic clear_row();
        fg_now      = COLOUR_WHITE;
        bg_now      = COLOUR_BLACK;
        mosaic_now  = 1'b0;
        sep_now     = 1'b0;
        conceal_now = 1'b0;
        flash_off   = 1'b0;
        hold_now    = 1'b0;
        held_code   = GLYPH_SPACE;
        last_code   = GLYPH_SPACE;
        ht_now      = HT_NORMAL;
    endtask

    task automatic decode_beat(input t_in beat);
        t_out       pred;
        logic [7:0] c;
        logic [7:0] hold_show;
        c = beat.char_code;
        case (beat.op)
            OP_ROW: begin
                clear_row();
                if (dh_phase != HT_NORMAL)
                    dh_phase = (dh_phase == HT_UPPER) ? HT_LOWER : HT_NORMAL;
            end
            OP_FRAME: begin
                frame_cnt = frame_cnt + 8'd1;
                if (frame_cnt == toggle_at) begin
                    flash_state = ~flash_state;
                end else if (frame_cnt == period_at) begin
                    flash_state = ~flash_state;
                    frame_cnt   = '0;
                end
                dh_phase = HT_NORMAL;
            end
            OP_CHAR: begin
                hold_show = hold_now ? held_code : GLYPH_SPACE;
                // background and conceal apply at their own cell
                if (c == CODE_BLACK_BG)     bg_now = COLOUR_BLACK;
                else if (c == CODE_NEW_BG)  bg_now = fg_now;
                else if (c == CODE_CONCEAL) conceal_now = 1'b1;

                pred.glyph       = GLYPH_SPACE;
                pred.mosaic      = mosaic_now;
                pred.separated   = mosaic_now & sep_now;
                pred.fg_colour   = fg_now;
                pred.bg_colour   = bg_now;
                pred.height_mode = ht_now;

                if (c < GLYPH_SPACE || c == CODE_ALPHA_BLACK || c == CODE_END_BOX ||
                    c == CODE_START_BOX || (c >= CODE_RSVD_LO && c <= CODE_RSVD_HI) ||
                    c == CODE_RSVD_ESC) begin
                    held_code = GLYPH_SPACE;
                end else if (c <= CODE_DEL || c > CODE_RELEASE) begin
                    pred.glyph = (flash_off || conceal_now) ? GLYPH_SPACE : c;
                    held_code  = GLYPH_SPACE;
                end else if (c <= CODE_ALPHA_WHITE) begin
                    mosaic_now  = 1'b0;
                    fg_now      = c[2:0];
                    conceal_now = 1'b0;
                    held_code   = GLYPH_SPACE;
                end else if (c == CODE_STEADY) begin
                    pred.glyph  = hold_show;
                    flash_off   = 1'b0;
                    conceal_now = 1'b0;
                end else if (c == CODE_FLASH) begin
                    pred.glyph  = hold_show;
                    flash_off   = flash_state;
                    conceal_now = 1'b0;
                end else if (c == CODE_NORMAL_HT) begin
                    pred.glyph = hold_show;
                    ht_now     = HT_NORMAL;
                end else if (c == CODE_DOUBLE_HT) begin
                    held_code = GLYPH_SPACE;
                    if (dh_phase == HT_LOWER) begin
                        ht_now = HT_LOWER;
                    end else begin
                        dh_phase = HT_UPPER;
                        ht_now   = HT_UPPER;
                    end
                end else if (c <= CODE_MOS_WHITE) begin
                    pred.glyph  = conceal_now ? GLYPH_SPACE : held_code;
                    conceal_now = 1'b0;
                    mosaic_now  = 1'b1;
                    fg_now      = c[2:0];
                end else if (c == CODE_CONCEAL) begin
                    held_code = GLYPH_SPACE;
                end else if (c == CODE_CONTIGUOUS) begin
                    pred.glyph = hold_show;
                    sep_now    = 1'b0;
                end else if (c == CODE_SEPARATED) begin
                    pred.glyph = hold_show;
                    sep_now    = 1'b1;
                end else if (c == CODE_HOLD) begin
                    hold_now   = 1'b1;
                    held_code  = mosaic_now ? last_code : GLYPH_SPACE;
                    pred.glyph = held_code;
                end else if (c == CODE_RELEASE) begin
                    held_code = GLYPH_SPACE;
                    hold_now  = 1'b0;
                end
                // black and new background leave a space

                last_code = c;
                pending_cells.push_back(pred);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : cell_check
        t_out want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_cells.size() == 0) begin
                $error("result beat with no cell expected");
                mismatch_count++;
            end else begin
                want = pending_cells.pop_front();
                check_field("glyph", want.glyph, o_out_data.glyph);
                check_field("mosaic", want.mosaic, o_out_data.mosaic);
                check_field("separated", want.separated, o_out_data.separated);
                check_field("fg_colour", want.fg_colour, o_out_data.fg_colour);
                check_field("bg_colour", want.bg_colour, o_out_data.bg_colour);
                check_field("height_mode", want.height_mode, o_out_data.height_mode);
            end
        end
    end

    // receiver back-pressure in random bursts, with ready raised again at the end of each burst
    always @(posedge i_clk) begin
        if (!idle_en) begin
            stall_left <= 0;
            out_ready  <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 18);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [1:0] op, input logic [7:0] code);
        t_in beat;
        int  gap;
        beat.op        = op;
        beat.char_code = code;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        decode_beat(beat);
    endtask

    // hold the sender until every cell is back, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_flash_timer(input logic [7:0] first, input logic [7:0] period);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FLASH_FIRST;
        cfg_data  <= first;
        do @(posedge i_clk); while (!o_cfg_ready);
        toggle_at = first;
        cfg_index <= CFG_FLASH_PERIOD;
        cfg_data  <= period;
        do @(posedge i_clk); while (!o_cfg_ready);
        period_at = period;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      return 8'($urandom_range(32, 127));
        else if (pick < 55) return 8'($urandom_range(160, 255));
        else if (pick < 90) return 8'($urandom_range(128, 159));
        else                return 8'($urandom_range(0, 31));
    endfunction

    task automatic test_directed();
        send_beat(OP_ROW, 8'hFF);
        send_beat(OP_CHAR, 8'h00);
        send_beat(OP_CHAR, 8'hFF);
        send_beat(OP_CHAR, CODE_ALPHA_RED);
        send_beat(OP_CHAR, CODE_NEW_BG);       // background takes red
        send_beat(OP_CHAR, 8'h41);
        send_beat(OP_CHAR, CODE_BLACK_BG);
        send_beat(OP_CHAR, CODE_MOS_RED);
        send_beat(OP_CHAR, 8'h3F);
        send_beat(OP_CHAR, CODE_HOLD);         // latches the mosaic byte
        send_beat(OP_CHAR, CODE_SEPARATED);
        send_beat(OP_CHAR, CODE_MOS_WHITE);
        send_beat(OP_CHAR, CODE_CONTIGUOUS);
        send_beat(OP_CHAR, CODE_CONCEAL);
        send_beat(OP_CHAR, 8'h61);
        send_beat(OP_CHAR, CODE_RELEASE);
        send_beat(OP_CHAR, CODE_DOUBLE_HT);
        send_beat(OP_CHAR, CODE_NORMAL_HT);
        send_beat(OP_ROW, 8'h00);              // next row is the lower half
        send_beat(OP_CHAR, CODE_DOUBLE_HT);
        send_beat(OP_CHAR, CODE_FLASH);
        send_beat(OP_CHAR, CODE_STEADY);
        send_beat(OP_CHAR, CODE_RSVD_ESC);
        send_beat(OP_FRAME, 8'h5A);
        send_beat(OP_UNUSED, 8'hA5);
    endtask

    task automatic run_flash(input logic [7:0] first, input logic [7:0] period,
                             input int frames, input bit dense);
        int f;
        write_flash_timer(first, period);
        send_beat(OP_ROW, 8'($urandom));
        for (f = 0; f < frames; f++) begin
            send_beat(OP_FRAME, 8'($urandom));
            if (dense || $urandom_range(0, 7) == 0) begin
                send_beat(OP_CHAR, CODE_FLASH);
                send_beat(OP_CHAR, 8'($urandom_range(33, 126)));
            end
        end
    endtask

    // equal registers need the count to wrap, and a first toggle beyond the period never fires
    task automatic test_flash_timer();
        run_flash(8'd1, 8'd2, 12, 1'b1);
        run_flash(8'd255, 8'd255, 260, 1'b0);
        run_flash(8'd200, 8'd3, 12, 1'b1);
        run_flash(8'd2, 8'd2, 260, 1'b0);
    endtask

    task automatic test_random_rows(input int n_beats);
        int sent;
        int row_len;
        int k;
        int pick;
        sent = 0;
        while (sent < n_beats) begin
            send_beat(OP_ROW, 8'($urandom));
            sent++;
            row_len = $urandom_range(1, 40);
            for (k = 0; k < row_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    send_beat(OP_FRAME, 8'($urandom));
                    sent++;
                end else if (pick == 3) begin
                    send_beat(OP_UNUSED, 8'($urandom));
                end else begin
                    send_beat(OP_CHAR, random_code());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        write_flash_timer(8'($urandom_range(1, 255)), 8'($urandom_range(2, 255)));
        test_random_rows(150);
    endtask

    initial begin
        toggle_at   = FLASH_FIRST_RESET;
        period_at   = FLASH_PERIOD_RESET;
        dh_phase    = HT_NORMAL;
        frame_cnt   = '0;
        flash_state = 1'b0;
        clear_row();
        repeat (3) @(posedge i_clk);
        rst_n   <= 1'b1;
        idle_en = 1'b1;

        test_directed();
        test_flash_timer();
        write_flash_timer(8'($urandom_range(1, 255)), 8'($urandom_range(2, 255)));
        test_random_rows(250);
        write_flash_timer(FLASH_FIRST_RESET, FLASH_PERIOD_RESET);
        test_random_rows(250);
        write_flash_timer(8'd255, 8'd2);
        test_random_rows(250);
        test_steady_stream();

        wait_idle();
        if (mismatch_count == 0 && pending_cells.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tad_pkg.sv
rtl/core/tad_front.sv
rtl/core/tad_queue.sv
rtl/core/tad_back.sv
rtl/core/teletext_attribute_decoder.sv
dv/tb_teletext_attribute_decoder.sv
